// ===== design/dsw_pkg.sv =====
// Package for the dive sample word decoder.
// Holds the sample type codes, event kind codes, dive mode codes and the event type.
// No dependencies.
package dsw_pkg;

    localparam int NumEvents = 6;
    localparam int CountW    = 3;

    // Sample word type, bits 1:0
    localparam logic [1:0] TYPE_DEPTH_A = 2'd0;
    localparam logic [1:0] TYPE_DEPTH_B = 2'd1;
    localparam logic [1:0] TYPE_SURFACE = 2'd2;
    localparam logic [1:0] TYPE_TEMP    = 2'd3;

    // Event kinds
    localparam logic [1:0] KIND_TIME  = 2'd0;
    localparam logic [1:0] KIND_TEMP  = 2'd1;
    localparam logic [1:0] KIND_DEPTH = 2'd2;
    localparam logic [1:0] KIND_GAS   = 2'd3;

    // Dive modes
    localparam logic [1:0] MODE_SCUBA    = 2'd0;
    localparam logic [1:0] MODE_NITROX   = 2'd1;
    localparam logic [1:0] MODE_FREEDIVE = 2'd2;
    localparam logic [1:0] MODE_GAUGE    = 2'd3;

    localparam logic [2:0] INTERVAL_FREEDIVE = 3'd2;
    localparam logic [2:0] INTERVAL_DEFAULT  = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
    } t_event;

endpackage

// ===== design/dive_sample_word_decoder.sv =====
// Dive sample word decoder top level.
// Decodes 16-bit sample words into time, temperature, depth and gas events.
// Depends on dsw_pkg.

// A sample word is decoded in the cycle it is accepted: the running state
// (elapsed seconds, gas, pending temperature) updates at once and the events
// a depth or surface word causes, two to six, are loaded into an output queue
// that issues one event per cycle while the master side is ready. Such a word
// therefore occupies the output until all of its events are taken, and the
// next word is taken in the same cycle as the last event of the previous
// one, so words stream back to back. A temperature word causes no event.
// first_of_dive on tuser clears the running state before its word;
// dive_mode is kept and should only be written while no events are
// outstanding.
module dive_sample_word_decoder
    import dsw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,      // dive_mode
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,     // [15:0] sample_word
    input  logic        i_s_axis_tuser,     // [0] first_of_dive
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,     // [31:0] event_value
    output logic [1:0]  o_m_axis_tuser,     // [1:0] event_kind
    output logic        o_m_axis_tlast      // last_event
);

    logic [1:0]  r_mode;
    logic [31:0] r_elapsed;
    logic        r_gas;
    logic        r_prev_gas;
    logic        r_prev_known;
    logic [13:0] r_temp;
    logic        r_temp_pend;

    t_event              r_ev [NumEvents];
    logic [CountW-1:0]   r_cnt;

    t_event              n_ev [NumEvents];
    logic [CountW-1:0]   n_cnt;

    logic        accept, pop, pop_last, load;
    logic [1:0]  wtype;
    logic [13:0] wvalue;
    logic        clr;
    logic [2:0]  interval;
    logic [31:0] e_elapsed;
    logic        e_gas, e_prev_gas, e_prev_known, e_temp_pend;
    logic [13:0] e_temp;
    logic [32:0] sum_int, sum_val;
    logic [31:0] t_int, t_val, t_final;
    logic        is_surface, surf_long;
    logic [10:0] new_depth;
    logic        new_gas;
    logic        gas_evt;

    assign wtype  = i_s_axis_tdata[1:0];
    assign wvalue = i_s_axis_tdata[15:2];
    assign clr    = i_s_axis_tuser;

    assign o_m_axis_tvalid = (r_cnt != '0);
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;
    assign pop_last        = pop && (r_cnt == CountW'(1));
    assign o_s_axis_tready = !o_m_axis_tvalid || pop_last;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign load            = accept && (wtype != TYPE_TEMP);

    assign o_m_axis_tdata = r_ev[0].value;
    assign o_m_axis_tuser = r_ev[0].kind;
    assign o_m_axis_tlast = (r_cnt == CountW'(1));

    // Running state as seen by this word, after an optional new-dive clear
    assign e_elapsed    = clr ? '0 : r_elapsed;
    assign e_gas        = clr ? 1'b0 : r_gas;
    assign e_prev_gas   = clr ? 1'b0 : r_prev_gas;
    assign e_prev_known = clr ? 1'b0 : r_prev_known;
    assign e_temp_pend  = clr ? 1'b0 : r_temp_pend;
    assign e_temp       = clr ? '0 : r_temp;

    assign interval = (r_mode == MODE_FREEDIVE) ? INTERVAL_FREEDIVE : INTERVAL_DEFAULT;

    // Saturating sums; interval then remainder equals a single saturating add
    assign sum_int = {1'b0, e_elapsed} + 33'(interval);
    assign sum_val = {1'b0, e_elapsed} + 33'(wvalue);
    assign t_int   = sum_int[32] ? '1 : sum_int[31:0];
    assign t_val   = sum_val[32] ? '1 : sum_val[31:0];

    assign is_surface = (wtype == TYPE_SURFACE);
    assign surf_long  = is_surface && (wvalue > 14'(interval));
    assign t_final    = is_surface ? t_val : t_int;
    assign new_depth  = is_surface ? '0 : wvalue[10:0];
    assign new_gas    = is_surface ? e_gas : wvalue[11];
    assign gas_evt    = ((r_mode == MODE_SCUBA) || (r_mode == MODE_NITROX))
                        && (!e_prev_known || (new_gas != e_prev_gas));

    // Build the event list for this word, or shift the queue on a take
    always_comb begin
        logic [CountW-1:0] idx;
        t_event            fresh [NumEvents];
        idx = '0;
        for (int k = 0; k < NumEvents; k++) begin
            fresh[k] = '{kind: KIND_TIME, value: '0};
        end
        if (surf_long) begin
            fresh[0] = '{kind: KIND_TIME, value: t_int};
            fresh[1] = '{kind: KIND_DEPTH, value: '0};
            idx = CountW'(2);
        end
        fresh[idx] = '{kind: KIND_TIME, value: t_final};
        idx = idx + CountW'(1);
        if (e_temp_pend) begin
            fresh[idx] = '{kind: KIND_TEMP, value: 32'(e_temp)};
            idx = idx + CountW'(1);
        end
        fresh[idx] = '{kind: KIND_DEPTH, value: 32'(new_depth)};
        idx = idx + CountW'(1);
        if (gas_evt) begin
            fresh[idx] = '{kind: KIND_GAS, value: 32'(new_gas)};
            idx = idx + CountW'(1);
        end

        for (int k = 0; k < NumEvents; k++) begin
            n_ev[k] = r_ev[k];
        end
        n_cnt = r_cnt;
        if (load) begin
            for (int k = 0; k < NumEvents; k++) begin
                n_ev[k] = fresh[k];
            end
            n_cnt = idx;
        end else if (pop) begin
            for (int k = 0; k < NumEvents - 1; k++) begin
                n_ev[k] = r_ev[k+1];
            end
            n_cnt = r_cnt - CountW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_SCUBA;
            r_elapsed    <= '0;
            r_gas        <= 1'b0;
            r_prev_gas   <= 1'b0;
            r_prev_known <= 1'b0;
            r_temp       <= '0;
            r_temp_pend  <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (accept) begin
                if (wtype == TYPE_TEMP) begin
                    r_elapsed    <= e_elapsed;
                    r_gas        <= e_gas;
                    r_prev_gas   <= e_prev_gas;
                    r_prev_known <= e_prev_known;
                    r_temp       <= wvalue;
                    r_temp_pend  <= 1'b1;
                end else begin
                    r_elapsed    <= t_final;
                    r_gas        <= new_gas;
                    r_prev_gas   <= gas_evt ? new_gas : e_prev_gas;
                    r_prev_known <= e_prev_known || gas_evt;
                    r_temp       <= e_temp;
                    r_temp_pend  <= 1'b0;
                end
            end
        end
    end

    // Event queue payload, no reset
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NumEvents; k++) begin
            r_ev[k] <= n_ev[k];
        end
    end

endmodule

// ===== design/dsw_checker.sv =====
// Port-level checks for the dive sample word decoder.
// Depends on dsw_pkg; bound to dive_sample_word_decoder below.
module dsw_checker
    import dsw_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [15:0] i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // Input may stall only while events are still queued
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    // Final event of a word is depth or gas
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |->
            (o_m_axis_tuser == KIND_DEPTH || o_m_axis_tuser == KIND_GAS))
        else $error("last event is not depth or gas");

    // More events follow a taken non-final event
    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=> o_m_axis_tvalid)
        else $error("events lost after non-final event");

    // A depth or surface word opens with a time event
    a_first_is_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tdata[1:0] != TYPE_TEMP)
            |=> (o_m_axis_tvalid && o_m_axis_tuser == KIND_TIME))
        else $error("word did not open with a time event");

    // Hold the output word while the master side stalls
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
             && $stable(o_m_axis_tlast)))
        else $error("output word changed while stalled");

endmodule

bind dive_sample_word_decoder dsw_checker u_dsw_checker (.*);

// ===== dv/dive_sample_word_decoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the dive sample word decoder: a directed table, then random dives.
// Uses dsw_pkg for the type, kind and mode codes; needs only the design files.
module dive_sample_word_decoder_tb;
    import dsw_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int WORDS_PER_PHASE = 68;
    localparam int MAX_PRINTED    = 40;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] word;
        logic        fresh;
        logic        pinned;
        logic [1:0]  pin_kind;
        logic [31:0] pin_value;
    } t_stim_row;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic        last;
        logic        pinned;
        logic [1:0]  pin_kind;
        logic [31:0] pin_value;
    } t_dive_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_wr_data = MODE_SCUBA;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    // table pin travels with the word it belongs to
    logic        drv_pinned = 1'b0;
    logic [1:0]  drv_pin_kind = KIND_TIME;
    logic [31:0] drv_pin_value = '0;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int mismatches = 0;
    int words_sent = 0;
    int events_checked = 0;
    int quiet_cycles = 0;

    // decoder shadow state
    logic [1:0]  mode_shadow = MODE_SCUBA;
    logic [31:0] dive_secs = '0;
    logic [10:0] dive_depth = '0;
    logic        gas_now = 1'b0;
    logic        gas_reported = 1'b0;
    logic        gas_reported_valid = 1'b0;
    logic [13:0] temp_held = '0;
    logic        temp_held_valid = 1'b0;

    t_dive_event pending_events[$];
    t_stim_row   dir_rows[$];

    dive_sample_word_decoder uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic logic [15:0] enc(input logic [1:0] ty, input logic [13:0] val);
        return {val, ty};
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Work out the events one accepted word causes and queue them.
    function automatic void decode_sample(input logic [15:0] w, input logic fresh,
                                          input logic pin_on, input logic [1:0] pin_kind,
                                          input logic [31:0] pin_value);
        logic [1:0]  ty;
        logic [13:0] val;
        logic [31:0] step;
        logic [31:0] rest;
        logic [1:0]  kinds[6];
        logic [31:0] vals[6];
        int          n;
        int          i;
        t_dive_event ev;
        ty = w[1:0];
        val = w[15:2];
        step = (mode_shadow == MODE_FREEDIVE) ? 32'(INTERVAL_FREEDIVE) : 32'(INTERVAL_DEFAULT);
        n = 0;
        if (fresh) begin
            dive_secs = '0;
            dive_depth = '0;
            gas_now = 1'b0;
            gas_reported = 1'b0;
            gas_reported_valid = 1'b0;
            temp_held = '0;
            temp_held_valid = 1'b0;
        end
        if (ty == TYPE_TEMP) begin
            temp_held = val;
            temp_held_valid = 1'b1;
        end else begin
            if (ty == TYPE_SURFACE) begin
                rest = 32'(val);
                // long gap: report one interval at zero depth first
                if (rest > step) begin
                    rest = rest - step;
                    dive_secs = sat_add(dive_secs, step);
                    kinds[n] = KIND_TIME;  vals[n] = dive_secs; n++;
                    kinds[n] = KIND_DEPTH; vals[n] = '0;        n++;
                end
                dive_secs = sat_add(dive_secs, rest);
                dive_depth = '0;
            end else begin
                dive_depth = val[10:0];
                gas_now = val[11];
                dive_secs = sat_add(dive_secs, step);
            end
            kinds[n] = KIND_TIME; vals[n] = dive_secs; n++;
            if (temp_held_valid) begin
                kinds[n] = KIND_TEMP; vals[n] = 32'(temp_held); n++;
                temp_held_valid = 1'b0;
            end
            kinds[n] = KIND_DEPTH; vals[n] = 32'(dive_depth); n++;
            if (mode_shadow == MODE_SCUBA || mode_shadow == MODE_NITROX) begin
                if (!gas_reported_valid || gas_now != gas_reported) begin
                    kinds[n] = KIND_GAS; vals[n] = 32'(gas_now); n++;
                    gas_reported = gas_now;
                    gas_reported_valid = 1'b1;
                end
            end
            for (i = 0; i < n; i++) begin
                ev.kind = kinds[i];
                ev.value = vals[i];
                ev.last = (i == n - 1);
                ev.pinned = pin_on && (i == n - 1);
                ev.pin_kind = pin_kind;
                ev.pin_value = pin_value;
                pending_events.push_back(ev);
            end
        end
    endfunction

    task automatic check_event();
        t_dive_event exp_ev;
        if (pending_events.size() == 0) begin
            report_mismatch($sformatf("event kind %0d value %0d with nothing outstanding",
                                      o_m_axis_tuser, o_m_axis_tdata));
        end else begin
            exp_ev = pending_events.pop_front();
            events_checked++;
            if (o_m_axis_tuser !== exp_ev.kind)
                report_mismatch($sformatf("kind %0d, want %0d", o_m_axis_tuser, exp_ev.kind));
            if (o_m_axis_tdata !== exp_ev.value)
                report_mismatch($sformatf("value %0d, want %0d (kind %0d)",
                                          o_m_axis_tdata, exp_ev.value, exp_ev.kind));
            if (o_m_axis_tlast !== exp_ev.last)
                report_mismatch($sformatf("tlast %0b, want %0b", o_m_axis_tlast, exp_ev.last));
            if (exp_ev.pinned && (o_m_axis_tuser !== exp_ev.pin_kind ||
                                  o_m_axis_tdata !== exp_ev.pin_value))
                report_mismatch($sformatf("final event %0d/%0d, table says %0d/%0d",
                                          o_m_axis_tuser, o_m_axis_tdata,
                                          exp_ev.pin_kind, exp_ev.pin_value));
        end
    endtask

    // Predict first so a same-cycle event would already have its expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                decode_sample(i_s_axis_tdata, i_s_axis_tuser, drv_pinned, drv_pin_kind,
                              drv_pin_value);
                words_sent++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready)
                check_event();
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("dive_sample_word_decoder regression: fail");
                $finish;
            end
        end
    end

    // Called right after a rising edge; returns at the edge that accepts the word.
    task automatic send_word(input logic [15:0] w, input logic fresh, input logic pin_on,
                             input logic [1:0] pin_kind, input logic [31:0] pin_value);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= w;
        i_s_axis_tuser <= fresh;
        drv_pinned <= pin_on;
        drv_pin_kind <= pin_kind;
        drv_pin_value <= pin_value;
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
    endtask

    // Hold the sender until every event is out, then let the block settle.
    task automatic drain_and_settle();
        i_s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_events.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        mode_shadow = m;
    endtask

    task automatic add_row(input logic [1:0] m, input logic [15:0] w, input logic fresh,
                           input logic pin_on, input logic [1:0] pk, input logic [31:0] pv);
        t_stim_row r;
        r.mode = m;
        r.word = w;
        r.fresh = fresh;
        r.pinned = pin_on;
        r.pin_kind = pk;
        r.pin_value = pv;
        dir_rows.push_back(r);
    endtask

    initial begin
        logic [1:0]  phase_modes[6];
        int          phase_src[6];
        int          phase_sink[6];
        logic [15:0] w;
        logic        fresh;
        logic        rnd_gas;
        int          pick;
        int          p;
        int          k;
        t_stim_row   r;

        phase_modes = '{MODE_SCUBA, MODE_NITROX, MODE_FREEDIVE, MODE_GAUGE,
                        MODE_FREEDIVE, MODE_SCUBA};
        phase_src  = '{0, 70, 0, 22, 70, 0};
        phase_sink = '{0, 0, 70, 22, 0, 70};
        rnd_gas = 1'b0;

        // scuba, 5 s interval
        add_row(MODE_SCUBA, enc(TYPE_DEPTH_A, 14'h0000), 1'b1, 1'b1, KIND_GAS, 0);
        add_row(MODE_SCUBA, enc(TYPE_DEPTH_A, 14'h07FF), 1'b0, 1'b1, KIND_DEPTH, 2047);
        add_row(MODE_SCUBA, enc(TYPE_DEPTH_A, 14'h0864), 1'b0, 1'b1, KIND_GAS, 1);
        add_row(MODE_SCUBA, enc(TYPE_DEPTH_B, 14'h3FFF), 1'b0, 1'b1, KIND_DEPTH, 2047);
        add_row(MODE_SCUBA, enc(TYPE_TEMP, 14'h3FFF), 1'b0, 1'b0, KIND_TIME, 0);
        // second temperature overwrites the first
        add_row(MODE_SCUBA, enc(TYPE_TEMP, 14'd250), 1'b0, 1'b0, KIND_TIME, 0);
        add_row(MODE_SCUBA, enc(TYPE_DEPTH_A, 14'h0832), 1'b0, 1'b1, KIND_DEPTH, 50);
        // surface gap equal to the interval: no extra pair
        add_row(MODE_SCUBA, enc(TYPE_SURFACE, 14'd5), 1'b0, 1'b1, KIND_DEPTH, 0);
        add_row(MODE_SCUBA, enc(TYPE_SURFACE, 14'd6), 1'b0, 1'b1, KIND_DEPTH, 0);
        add_row(MODE_SCUBA, enc(TYPE_TEMP, 14'd0), 1'b0, 1'b0, KIND_TIME, 0);
        add_row(MODE_SCUBA, enc(TYPE_SURFACE, 14'h3FFF), 1'b0, 1'b1, KIND_DEPTH, 0);
        add_row(MODE_SCUBA, enc(TYPE_DEPTH_A, 14'd1), 1'b0, 1'b1, KIND_GAS, 0);
        // new dive, pending temperature, long gap: six events
        add_row(MODE_SCUBA, enc(TYPE_TEMP, 14'd77), 1'b1, 1'b0, KIND_TIME, 0);
        add_row(MODE_SCUBA, enc(TYPE_SURFACE, 14'd20), 1'b0, 1'b1, KIND_GAS, 0);
        add_row(MODE_SCUBA, enc(TYPE_SURFACE, 14'd0), 1'b1, 1'b1, KIND_GAS, 0);
        add_row(MODE_SCUBA, enc(TYPE_DEPTH_B, 14'h0FFF), 1'b1, 1'b1, KIND_GAS, 1);
        add_row(MODE_SCUBA, 16'hFFFF, 1'b0, 1'b0, KIND_TIME, 0);
        add_row(MODE_SCUBA, 16'hFFFD, 1'b0, 1'b1, KIND_DEPTH, 2047);
        // freedive, 2 s interval, no gas events; then one gauge and one nitrox word
        add_row(MODE_FREEDIVE, enc(TYPE_SURFACE, 14'd2), 1'b1, 1'b1, KIND_DEPTH, 0);
        add_row(MODE_FREEDIVE, enc(TYPE_SURFACE, 14'd3), 1'b0, 1'b1, KIND_DEPTH, 0);
        add_row(MODE_GAUGE, enc(TYPE_DEPTH_A, 14'h0809), 1'b1, 1'b1, KIND_DEPTH, 9);
        add_row(MODE_NITROX, enc(TYPE_DEPTH_A, 14'd9), 1'b1, 1'b1, KIND_GAS, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_mode(MODE_SCUBA);

        src_idle_pct = 22;
        sink_stall_pct = 22;
        foreach (dir_rows[k]) begin
            r = dir_rows[k];
            if (r.mode != mode_shadow) begin
                drain_and_settle();
                write_mode(r.mode);
            end
            send_word(r.word, r.fresh, r.pinned, r.pin_kind, r.pin_value);
        end

        for (p = 0; p < 6; p++) begin
            drain_and_settle();
            write_mode(phase_modes[p]);
            src_idle_pct = phase_src[p];
            sink_stall_pct = phase_sink[p];
            for (k = 0; k < WORDS_PER_PHASE; k++) begin
                pick = $urandom_range(0, 99);
                fresh = ($urandom_range(0, 39) == 0);
                if (pick < 55) begin
                    if ($urandom_range(0, 99) < 15)
                        rnd_gas = ~rnd_gas;
                    w = enc($urandom_range(0, 1) ? TYPE_DEPTH_B : TYPE_DEPTH_A,
                            {2'($urandom_range(0, 3)), rnd_gas, 11'($urandom_range(0, 2047))});
                end else if (pick < 70) begin
                    // mostly gaps around the interval, some long ones
                    w = enc(TYPE_SURFACE, ($urandom_range(0, 3) == 0) ?
                            14'($urandom_range(0, 16383)) : 14'($urandom_range(0, 10)));
                end else if (pick < 90) begin
                    w = enc(TYPE_TEMP, 14'($urandom_range(0, 16383)));
                end else begin
                    w = 16'($urandom_range(0, 65535));
                    fresh = 1'($urandom_range(0, 1));
                end
                send_word(w, fresh, 1'b0, KIND_TIME, '0);
            end
        end

        drain_and_settle();
        $display("covered %0d sample words (directed table and six random phases), %0d events",
                 words_sent, events_checked);
        $display("all four dive modes, idle and stall mixes up to 70 percent, %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("dive_sample_word_decoder regression: pass");
        end else begin
            $display("dive_sample_word_decoder regression: fail");
        end
        $finish;
    end

endmodule
